@@ rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and UTF-8 encoding helpers for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // One encoding job: up to four UTF-8 bytes, sent in order from bytes[0].
  // A job with nbytes == 0 stands for a single end-only result.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            last;
  } job_t;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;  // 0xD800 .. 0xDBFF
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;  // 0xDC00 .. 0xDFFF
  localparam logic [7:0] BOM_FF      = 8'hFF;
  localparam logic [7:0] BOM_FE      = 8'hFE;
  localparam logic [7:0] LEAD2       = 8'hC0;
  localparam logic [7:0] LEAD3       = 8'hE0;
  localparam logic [7:0] LEAD4       = 8'hF0;
  localparam logic [7:0] CONT        = 8'h80;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // Encode one 16-bit code point (surrogates included) as 1 to 3 bytes.
  function automatic job_t enc_bmp(input logic [15:0] cp);
    job_t j;
    j = '0;
    if (cp[15:7] == 9'd0) begin
      j.bytes[0] = {1'b0, cp[6:0]};
      j.nbytes   = 3'd1;
    end else if (cp[15:11] == 5'd0) begin
      j.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
      j.bytes[1] = CONT | {2'b00, cp[5:0]};
      j.nbytes   = 3'd2;
    end else begin
      j.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
      j.bytes[1] = CONT | {2'b00, cp[11:6]};
      j.bytes[2] = CONT | {2'b00, cp[5:0]};
      j.nbytes   = 3'd3;
    end
    return j;
  endfunction

  // Encode a surrogate pair as a 4-byte sequence.
  function automatic job_t enc_pair(input logic [9:0] hi, input logic [9:0] lo);
    job_t        j;
    logic [20:0] full;
    j        = '0;
    full     = SUPP_BASE + {1'b0, hi, lo};
    j.bytes[0] = LEAD4 | {5'b00000, full[20:18]};
    j.bytes[1] = CONT | {2'b00, full[17:12]};
    j.bytes[2] = CONT | {2'b00, full[11:6]};
    j.bytes[3] = CONT | {2'b00, full[5:0]};
    j.nbytes   = 3'd4;
    return j;
  endfunction

endpackage

@@ rtl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Byte intake: mark check, code unit assembly, surrogate pairing, job issue.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_byte,
  input  logic              has_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_wr,
  output u16u8_pkg::job_t   q_wr_data
);
  import u16u8_pkg::*;

  logic [1:0] byte_position, byte_position_next;
  logic       big_endian_mode, big_endian_mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [9:0] pend_bits, pend_bits_next;
  logic       pend_valid, pend_valid_next;

  logic       spill_valid;
  job_t       spill;

  logic       accept;
  logic       unit_v;
  logic [15:0] unit_cp;
  logic       is_hi, is_lo;
  logic       a_v, b_v;
  job_t       job_a, job_b;

  assign full   = spill_valid | q_full;
  assign accept = push & ~full;
  assign is_hi  = unit_cp[15:10] == HI_SURR_TAG;
  assign is_lo  = unit_cp[15:10] == LO_SURR_TAG;

  // Code unit assembly and byte-order mark detection.
  always_comb begin
    byte_position_next   = byte_position;
    big_endian_mode_next = big_endian_mode;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    unit_v               = 1'b0;
    unit_cp              = {in_byte, held_byte};
    if (has_byte) begin
      unique case (byte_position)
        2'd0: begin
          held_byte_next     = in_byte;
          held_valid_next    = 1'b1;
          byte_position_next = 2'd1;
        end
        2'd1: begin
          byte_position_next = 2'd2;
          held_valid_next    = 1'b0;
          if (held_byte == BOM_FF && in_byte == BOM_FE) begin
            big_endian_mode_next = 1'b0;
          end else if (held_byte == BOM_FE && in_byte == BOM_FF) begin
            big_endian_mode_next = 1'b1;
          end else begin
            unit_v = 1'b1;
          end
        end
        default: begin
          if (!held_valid) begin
            held_byte_next  = in_byte;
            held_valid_next = 1'b1;
          end else begin
            held_valid_next = 1'b0;
            unit_v          = 1'b1;
            unit_cp = big_endian_mode ? {held_byte, in_byte} : {in_byte, held_byte};
          end
        end
      endcase
    end
  end

  // Surrogate pairing and job selection: at most two jobs per item.
  always_comb begin
    a_v             = 1'b0;
    b_v             = 1'b0;
    job_a           = '0;
    job_b           = enc_bmp(unit_cp);
    pend_bits_next  = pend_bits;
    pend_valid_next = pend_valid;
    if (pend_valid && unit_v && is_lo) begin
      a_v             = 1'b1;
      job_a           = enc_pair(pend_bits, unit_cp[9:0]);
      pend_valid_next = 1'b0;
    end else begin
      if (pend_valid && (unit_v || in_last)) begin
        a_v             = 1'b1;
        job_a           = enc_bmp({HI_SURR_TAG, pend_bits});
        pend_valid_next = 1'b0;
      end
      if (unit_v) begin
        if (is_hi && !in_last) begin
          pend_bits_next  = unit_cp[9:0];
          pend_valid_next = 1'b1;
        end else begin
          b_v = 1'b1;
        end
      end
    end
    // Tag the final result of the stream; close an empty step with an end-only job.
    if (in_last) begin
      if (b_v) begin
        job_b.last = 1'b1;
      end else if (a_v) begin
        job_a.last = 1'b1;
      end else begin
        a_v        = 1'b1;
        job_a      = '0;
        job_a.last = 1'b1;
      end
    end
  end

  // Queue write: spill first, else the first job of the accepted item.
  always_comb begin
    q_wr      = 1'b0;
    q_wr_data = a_v ? job_a : job_b;
    if (spill_valid) begin
      q_wr      = ~q_full;
      q_wr_data = spill;
    end else if (accept && (a_v || b_v)) begin
      q_wr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 2'd0;
      big_endian_mode <= 1'b0;
      held_byte       <= 8'd0;
      held_valid      <= 1'b0;
      pend_bits       <= 10'd0;
      pend_valid      <= 1'b0;
      spill_valid     <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          // End of stream: return to the fresh-stream state.
          byte_position   <= 2'd0;
          big_endian_mode <= 1'b0;
          held_byte       <= 8'd0;
          held_valid      <= 1'b0;
          pend_bits       <= 10'd0;
          pend_valid      <= 1'b0;
        end else begin
          byte_position   <= byte_position_next;
          big_endian_mode <= big_endian_mode_next;
          held_byte       <= held_byte_next;
          held_valid      <= held_valid_next;
          pend_bits       <= pend_bits_next;
          pend_valid      <= pend_valid_next;
        end
      end
      if (spill_valid) begin
        if (!q_full) spill_valid <= 1'b0;
      end else if (accept && a_v && b_v) begin
        spill_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!spill_valid && accept && a_v && b_v) spill <= job_b;
  end

endmodule

@@ rtl/u16u8_fifo.sv @@
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  u16u8_pkg::job_t wr_data,
  output logic            q_full,
  input  logic            rd,
  output u16u8_pkg::job_t rd_data,
  output logic            q_avail
);
  import u16u8_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign q_full  = count == CW'(DEPTH);
  assign q_avail = count != '0;
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & q_avail;
  assign rd_data = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

@@ rtl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Job serializer: one UTF-8 byte per cycle into the result register if free.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_avail,
  input  u16u8_pkg::job_t rd_data,
  output logic            rd,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            out_empty,
  output logic            out_last
);
  import u16u8_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       ovalid;
  logic       adv, final_res;
  logic [2:0] nres;

  assign nres      = (cur.nbytes == 3'd0) ? 3'd1 : cur.nbytes;
  assign final_res = {1'b0, idx} == nres - 3'd1;
  assign adv       = cur_valid & (~ovalid | pop);
  assign rd        = q_avail & (~cur_valid | (adv & final_res));
  assign empty     = ~ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      ovalid    <= 1'b0;
    end else begin
      if (adv) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      if (rd) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (adv) begin
        if (final_res) begin
          cur_valid <= 1'b0;
          idx       <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd) cur <= rd_data;
    if (adv) begin
      out_byte  <= (cur.nbytes == 3'd0) ? 8'd0 : cur.bytes[idx];
      out_empty <= cur.nbytes == 3'd0;
      out_last  <= cur.last & final_res;
    end
  end

endmodule

@@ rtl/utf16_to_utf8_transcoder_core.sv @@
// Path: an item's first result passes the job queue, job register and result register.
// Throughput: one UTF-8 byte leaves per cycle and an input byte is taken per cycle; a
// two-job item holds input while its second job waits, as does a full job queue (units
// of three or four UTF-8 bytes outrun the output, as does a slow consumer).
// Reset: synchronous rst empties the job queue and the result register and starts
// a fresh stream (mark check pending, little-endian, nothing held).
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Byte-serial UTF-16 (with optional byte-order mark) to UTF-8 transcoder.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core #(
  parameter int JOB_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // input queue side: a transaction moves on push & !full
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       has_byte,
  input  logic       in_last,
  // result queue side: a transaction moves on pop & !empty
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_empty,
  output logic       out_last
);
  import u16u8_pkg::*;

  // Front -> queue
  logic q_wr;
  job_t q_wr_data;
  logic q_full;
  // Queue -> back
  logic q_rd;
  job_t q_rd_data;
  logic q_avail;

  // Front: hold the first byte of each unit, drop a leading byte-order mark,
  // pair surrogates and turn every input transaction into at most two jobs.
  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .has_byte  (has_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  // Queue: decouple intake stalls from output back-pressure.
  u16u8_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .q_avail (q_avail)
  );

  // Back: move each job one byte a cycle into the result register while it is free or
  // popped; the next job loads while the last byte of the current one goes out.
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .rd_data   (q_rd_data),
    .rd        (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_empty (out_empty),
    .out_last  (out_last)
  );

endmodule
